// ===== rtl/core/plcm_pkg.sv =====
// shared types, widths and boot calibration tables of the calibration map
`default_nettype none
package plcm_pkg;

  localparam int DistW  = 16;
  localparam int StepW  = 16;
  localparam logic [4:0] NoBracket = 5'd16;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_WRITE = 1'b1
  } plcm_op_e;

  // data that travels beside the divider
  typedef struct packed {
    plcm_op_e          op;
    logic              oor;
    logic [4:0]        bracket;
    logic              neg;
    logic signed [StepW-1:0] lo_s;
  } plcm_side_t;

  function automatic logic [DistW-1:0] boot_dist(input int i);
    logic [DistW-1:0] v;
    v = '0;
    case (i)
      0: v = 16'd25;   1: v = 16'd50;   2: v = 16'd75;   3: v = 16'd100;
      4: v = 16'd125;  5: v = 16'd175;  6: v = 16'd250;  7: v = 16'd350;
      8: v = 16'd500;  9: v = 16'd650;  10: v = 16'd800;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [StepW-1:0] boot_steps(input int i);
    logic [StepW-1:0] v;
    v = '0;
    case (i)
      0: v = 16'd5;   1: v = 16'd8;   2: v = 16'd12;  3: v = 16'd17;
      4: v = 16'd24;  5: v = 16'd30;  6: v = 16'd34;  7: v = 16'd40;
      8: v = 16'd46;  9: v = 16'd52;  10: v = 16'd58;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/piecewise_linear_calibration_map_unit.sv =====
// top level of the piecewise-linear distance to step calibration map
`default_nettype none
// Maps a distance to a step count over a table of MAX_POINTS (distance, steps)
// breakpoints held in flip-flops that reset to the boot calibration. Every
// item, write or query, gives exactly one result. A write stores one pair and
// returns zeros; a query finds the first breakpoint in use whose distance lies
// above it and interpolates from the one before (or from the origin), with the
// quotient truncated toward zero. A query past the last breakpoint in use
// returns 0 with out_of_range set and bracket 16. The pipeline takes one item
// per cycle while no result waits unclaimed, through one search stage, one difference
// stage, one 16x16 multiply stage, a 16-stage bit-per-stage divider and the
// output register. The whole pipeline holds while a result waits unclaimed.
// points_in_use is written through the always ready cfg channel; the user must
// write it only while no item is in flight, which the block does not enforce.
module piecewise_linear_calibration_map_unit #(
  parameter int MAX_POINTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,
  // item input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [15:0] entry_distance_i,
  input  wire logic signed [15:0] entry_steps_i,
  input  wire logic [15:0] query_distance_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [15:0] target_steps_o,
  output logic             out_of_range_o,
  output logic [4:0]       bracket_o
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic en, acc;
  logic [4:0] points_q;

  // calibration table, reset to boot values
  logic [15:0] dist_q  [MAX_POINTS];
  logic [15:0] steps_q [MAX_POINTS];

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign acc         = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= 5'd11;
    end else if (cfg_valid_i) begin
      points_q <= cfg_data_i;
    end
  end

  // table write on an accepted write item, slots past the table are dropped
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_tab
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dist_q[i]  <= plcm_pkg::boot_dist(i);
        steps_q[i] <= plcm_pkg::boot_steps(i);
      end else if (acc && opcode_i == plcm_pkg::OP_WRITE
                   && {3'b000, entry_index_i} == 7'(i)) begin
        dist_q[i]  <= entry_distance_i;
        steps_q[i] <= entry_steps_i;
      end
    end
  end

  // ---- stage 1: search for the bracket and fetch its two breakpoints
  logic [6:0]    used;
  logic [IW-1:0] b_idx;
  logic          found;
  logic [15:0]   lo_d, hi_d;
  logic [15:0]   lo_s, hi_s;

  always_comb begin
    used  = (7'(points_q) > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : 7'(points_q);
    found = 1'b0;
    b_idx = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (!found && 7'(i) < used && query_distance_i < dist_q[i]) begin
        found = 1'b1;
        b_idx = IW'(i);
      end
    end
    hi_d = dist_q[b_idx];
    hi_s = steps_q[b_idx];
    if (b_idx == '0) begin
      lo_d = '0;
      lo_s = '0;
    end else begin
      lo_d = dist_q[b_idx - IW'(1)];
      lo_s = steps_q[b_idx - IW'(1)];
    end
  end

  logic          s1_v_q, s1_op_q, s1_oor_q;
  logic [4:0]    s1_b_q;
  logic [15:0]   s1_q_q, s1_lod_q, s1_hid_q;
  logic signed [15:0] s1_los_q, s1_his_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q  <= opcode_i;
      s1_oor_q <= !found;
      s1_b_q   <= 5'(b_idx);
      s1_q_q   <= query_distance_i;
      s1_lod_q <= lo_d;
      s1_hid_q <= hi_d;
      s1_los_q <= lo_s;
      s1_his_q <= hi_s;
    end
  end

  // ---- stage 2: offset, step difference magnitude and span
  logic signed [16:0] ds;
  logic               s2_v_q;
  logic [15:0]        s2_num_q, s2_dsm_q, s2_den_q;
  plcm_pkg::plcm_side_t s2_side_q;

  assign ds = 17'(s1_his_q) - 17'(s1_los_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_num_q          <= s1_q_q - s1_lod_q;
      s2_dsm_q          <= ds[16] ? 16'(-ds) : ds[15:0];
      s2_den_q          <= s1_hid_q - s1_lod_q;
      s2_side_q.op      <= plcm_pkg::plcm_op_e'(s1_op_q);
      s2_side_q.oor     <= s1_oor_q;
      s2_side_q.bracket <= s1_b_q;
      s2_side_q.neg     <= ds[16];
      s2_side_q.lo_s    <= s1_los_q;
    end
  end

  // ---- stage 3: unsigned product
  logic                 s3_v_q;
  logic [31:0]          s3_prod_q;
  logic [15:0]          s3_den_q;
  plcm_pkg::plcm_side_t s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_q <= {16'b0, s2_num_q} * {16'b0, s2_dsm_q};
      s3_den_q  <= s2_den_q;
      s3_side_q <= s2_side_q;
    end
  end

  // ---- divider
  logic                 dv_v;
  logic [15:0]          dv_quo;
  plcm_pkg::plcm_side_t dv_side;

  plcm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .dvd_i   (s3_prod_q),
    .den_i   (s3_den_q),
    .side_i  (s3_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ---- output register
  logic        out_v_q, oor_q;
  logic [15:0] tgt_q;
  logic [4:0]  brk_q;
  logic [15:0] res;

  assign res = dv_side.lo_s + (dv_side.neg ? -dv_quo : dv_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_side.op == plcm_pkg::OP_WRITE) begin
        tgt_q <= '0;
        oor_q <= 1'b0;
        brk_q <= '0;
      end else if (dv_side.oor) begin
        tgt_q <= '0;
        oor_q <= 1'b1;
        brk_q <= plcm_pkg::NoBracket;
      end else begin
        tgt_q <= res;
        oor_q <= 1'b0;
        brk_q <= dv_side.bracket;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign target_steps_o = tgt_q;
  assign out_of_range_o = oor_q;
  assign bracket_o      = brk_q;

endmodule
`default_nettype wire

// ===== rtl/core/plcm_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module plcm_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [31:0]            dvd_i,   // quotient known to fit in 16 bits
  input  wire logic [15:0]            den_i,
  input  wire plcm_pkg::plcm_side_t   side_i,
  output logic                        valid_o,
  output logic [15:0]                 quo_o,
  output plcm_pkg::plcm_side_t        side_o
);

  localparam int NStg = 16;

  logic                 v_q    [NStg];
  logic [15:0]          rem_q  [NStg];
  logic [15:0]          low_q  [NStg];
  logic [15:0]          den_q  [NStg];
  plcm_pkg::plcm_side_t side_q [NStg];

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic                 v_in;
    logic [15:0]          rem_in, low_in, den_in;
    plcm_pkg::plcm_side_t side_in;
    logic [16:0]          trial, diff;
    logic                 qbit;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = dvd_i[31:16];
      assign low_in  = dvd_i[15:0];
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[15]};
      diff  = trial - {1'b0, den_in};
      qbit  = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= qbit ? diff[15:0] : trial[15:0];
        low_q[k]  <= {low_in[14:0], qbit};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NStg-1];
  assign quo_o   = low_q[NStg-1];
  assign side_o  = side_q[NStg-1];

endmodule
`default_nettype wire
